// File: rtl/vrt_pkg.sv
`default_nettype none
package vrt_pkg;

  localparam int WORLD_CHUNKS_X = 4;
  localparam int WORLD_CHUNKS_Z = 4;
  localparam int CHUNK_WIDTH    = 16;
  localparam int CHUNK_DEPTH    = 16;
  localparam int CHUNK_HEIGHT   = 64;

  localparam int STORE_SIDE = 64;
  localparam int ROW_COUNT  = 4096;
  localparam int ROW_AW     = 12;

  localparam int CELLS_X = WORLD_CHUNKS_X * CHUNK_WIDTH;
  localparam int CELLS_Y = CHUNK_HEIGHT;
  localparam int CELLS_Z = WORLD_CHUNKS_Z * CHUNK_DEPTH;
  localparam int LIM_X = (CELLS_X < STORE_SIDE) ? CELLS_X : STORE_SIDE;
  localparam int LIM_Y = (CELLS_Y < STORE_SIDE) ? CELLS_Y : STORE_SIDE;
  localparam int LIM_Z = (CELLS_Z < STORE_SIDE) ? CELLS_Z : STORE_SIDE;

  localparam int CELL_W = 18;
  localparam int DIV_W  = 31;

  localparam logic [15:0] REACH_RESET = 16'd1536;
  localparam logic [31:0] TINF        = 32'hFFFF_FFFF;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RAY   = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_WALK  = 5'b01000,
    ST_CHECK = 5'b10000
  } state_t;

endpackage
`default_nettype wire

// File: rtl/voxel_ray_traversal_unit.sv
`default_nettype none
// Channel    | Handshake                 | Payload
// ---------- | ------------------------- | -----------------------------------------
// input      | start, busy (start&!busy) | in_operation, in_row_index, in_row_bits,
//            |                           | in_origin_x/y/z, in_dir_x/y/z
// result     | out_valid (one cycle)     | out_hit, out_block_x/y/z
// config     | cfg_valid, cfg_ready      | cfg_reach_distance
//
// After reset the occupancy memory is cleared one row per cycle, all 4096 rows,
// with busy high. A row write is taken without leaving idle and busy stays low.
// After the accepting edge a ray runs six divisions on the shared divider,
// then for each voxel visited one memory read and one check and step, plus
// a step to see that reach is used up when no solid voxel is met. The result
// beat is registered, with busy already low when it shows. The receiver cannot
// stall: each result beat is shown for exactly one cycle.
module voxel_ray_traversal_unit (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire                  in_operation,
  input  wire  [11:0]          in_row_index,
  input  wire  [63:0]          in_row_bits,
  input  wire  signed [31:0]   in_origin_x,
  input  wire  signed [31:0]   in_origin_y,
  input  wire  signed [31:0]   in_origin_z,
  input  wire  signed [15:0]   in_dir_x,
  input  wire  signed [15:0]   in_dir_y,
  input  wire  signed [15:0]   in_dir_z,
  output logic                 out_valid,
  output logic                 out_hit,
  output logic [5:0]           out_block_x,
  output logic [5:0]           out_block_y,
  output logic [5:0]           out_block_z,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [15:0]          cfg_reach_distance
);
  import vrt_pkg::*;

  // Control state.
  state_t              state_r, state_nxt;
  logic [ROW_AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [4:0]          div_cnt_r, div_cnt_nxt;
  logic                div_phase_r, div_phase_nxt;   // 0: tDelta, 1: tMax
  logic [1:0]          ax_r, ax_nxt;
  logic [15:0]         reach_r;
  logic                out_valid_r, out_valid_nxt;

  // Payload state.
  logic signed [CELL_W-1:0] cell_r [3];
  logic signed [CELL_W-1:0] cell_nxt [3];
  logic [15:0]         frac_r [3];
  logic [15:0]         adir_r [3];
  logic                pos_r [3];
  logic                zero_r [3];
  logic [31:0]         tmax_r [3];
  logic [31:0]         tmax_nxt [3];
  logic [31:0]         tdel_r [3];
  logic [31:0]         tdel_nxt [3];
  logic [31:0]         trav_r, trav_nxt;
  logic [15:0]         rem_r, rem_nxt;
  logic [DIV_W-1:0]    quo_r, quo_nxt;
  logic                hit_r, hit_nxt;
  logic [5:0]          bx_r, bx_nxt, by_r, by_nxt, bz_r, bz_nxt;

  // Occupancy memory.
  logic [63:0]         mem [ROW_COUNT];
  logic [63:0]         rdata_r;
  logic                mem_we;
  logic [ROW_AW-1:0]   mem_waddr;
  logic [63:0]         mem_wdata;
  logic [ROW_AW-1:0]   mem_raddr;

  logic                accept;
  logic [16:0]         trial;
  logic                trial_ge;
  logic [DIV_W-1:0]    quo_done;
  logic [16:0]         num;
  logic [DIV_W-1:0]    dividend;
  logic                in_world;
  logic                solid;
  logic                take_x, take_y;
  logic [1:0]          pick;
  logic [32:0]         step_sum;
  logic [31:0]         step_sat;
  logic [15:0]         adir_x, adir_y, adir_z;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_hit   = hit_r;
  assign out_block_x = bx_r;
  assign out_block_y = by_r;
  assign out_block_z = bz_r;

  assign adir_x = in_dir_x[15] ? 16'(-in_dir_x) : in_dir_x;
  assign adir_y = in_dir_y[15] ? 16'(-in_dir_y) : in_dir_y;
  assign adir_z = in_dir_z[15] ? 16'(-in_dir_z) : in_dir_z;

  // Shared restoring divider, one quotient bit per cycle.
  assign trial    = {rem_r, quo_r[DIV_W-1]};
  assign trial_ge = trial >= {1'b0, adir_r[ax_r]};
  assign quo_done = {quo_r[DIV_W-2:0], trial_ge};

  // Distance to the next boundary of the axis that the divider moves to next.
  always_comb begin
    logic [1:0] nax;
    nax = div_phase_r ? ((ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1) : ax_r;
    num = pos_r[nax] ? (17'h10000 - {1'b0, frac_r[nax]}) : {1'b0, frac_r[nax]};
    dividend = div_phase_r ? 31'h4000_0000 : {num, 14'b0};
  end

  // Cell test and axis choice for the walk.
  assign in_world = !cell_r[0][CELL_W-1] && cell_r[0] < CELL_W'(LIM_X) &&
                    !cell_r[1][CELL_W-1] && cell_r[1] < CELL_W'(LIM_Y) &&
                    !cell_r[2][CELL_W-1] && cell_r[2] < CELL_W'(LIM_Z);
  assign solid  = in_world && rdata_r[cell_r[0][5:0]];
  assign take_x = (tmax_r[0] < tmax_r[1]) && (tmax_r[0] < tmax_r[2]);
  assign take_y = tmax_r[1] < tmax_r[2];
  assign pick   = take_x ? 2'd0 : (take_y ? 2'd1 : 2'd2);
  assign step_sum = {1'b0, tmax_r[pick]} + {1'b0, tdel_r[pick]};
  assign step_sat = step_sum[32] ? TINF : step_sum[31:0];
  assign mem_raddr = {cell_r[1][5:0], cell_r[2][5:0]};

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    div_cnt_nxt   = div_cnt_r;
    div_phase_nxt = div_phase_r;
    ax_nxt        = ax_r;
    out_valid_nxt = 1'b0;
    trav_nxt      = trav_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    hit_nxt       = hit_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    bz_nxt        = bz_r;
    for (int i = 0; i < 3; i++) begin
      cell_nxt[i] = cell_r[i];
      tmax_nxt[i] = tmax_r[i];
      tdel_nxt[i] = tdel_r[i];
    end
    mem_we    = 1'b0;
    mem_waddr = in_row_index;
    mem_wdata = in_row_bits;

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ROW_AW'(ROW_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == OP_WRITE) begin
            mem_we = 1'b1;
          end else begin
            cell_nxt[0] = CELL_W'(in_origin_x >>> 16);
            cell_nxt[1] = CELL_W'(in_origin_y >>> 16);
            cell_nxt[2] = CELL_W'(in_origin_z >>> 16);
            ax_nxt        = 2'd0;
            div_phase_nxt = 1'b0;
            div_cnt_nxt   = '0;
            rem_nxt       = '0;
            quo_nxt       = 31'h4000_0000;
            trav_nxt      = '0;
            state_nxt     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = trial_ge ? 16'(trial - {1'b0, adir_r[ax_r]}) : trial[15:0];
        quo_nxt = quo_done;
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == 5'(DIV_W - 1)) begin
          if (div_phase_r) begin
            tmax_nxt[ax_r] = zero_r[ax_r] ? TINF : 32'(quo_done);
          end else begin
            tdel_nxt[ax_r] = zero_r[ax_r] ? TINF : 32'(quo_done);
          end
          div_cnt_nxt = '0;
          rem_nxt     = '0;
          quo_nxt     = dividend;
          div_phase_nxt = !div_phase_r;
          if (div_phase_r) begin
            if (ax_r == 2'd2) begin
              state_nxt = ST_WALK;
            end else begin
              ax_nxt = ax_r + 2'd1;
            end
          end
        end
      end
      ST_WALK: begin
        if (trav_r < {8'b0, reach_r, 8'b0}) begin
          state_nxt = ST_CHECK;
        end else begin
          hit_nxt = 1'b0;
          bx_nxt = '0;
          by_nxt = '0;
          bz_nxt = '0;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (solid) begin
          hit_nxt = 1'b1;
          bx_nxt = cell_r[0][5:0];
          by_nxt = cell_r[1][5:0];
          bz_nxt = cell_r[2][5:0];
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cell_nxt[pick] = pos_r[pick] ? cell_r[pick] + CELL_W'(1) : cell_r[pick] - CELL_W'(1);
          trav_nxt       = tmax_r[pick];
          tmax_nxt[pick] = step_sat;
          state_nxt      = ST_WALK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      div_cnt_r   <= '0;
      div_phase_r <= 1'b0;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
      reach_r     <= REACH_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      div_cnt_r   <= div_cnt_nxt;
      div_phase_r <= div_phase_nxt;
      ax_r        <= ax_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        reach_r <= cfg_reach_distance;
      end
    end
  end

  always_ff @(posedge clk) begin
    trav_r <= trav_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    hit_r  <= hit_nxt;
    bx_r   <= bx_nxt;
    by_r   <= by_nxt;
    bz_r   <= bz_nxt;
    for (int i = 0; i < 3; i++) begin
      cell_r[i] <= cell_nxt[i];
      tmax_r[i] <= tmax_nxt[i];
      tdel_r[i] <= tdel_nxt[i];
    end
    if (accept) begin
      frac_r[0] <= in_origin_x[15:0];
      frac_r[1] <= in_origin_y[15:0];
      frac_r[2] <= in_origin_z[15:0];
      adir_r[0] <= adir_x;
      adir_r[1] <= adir_y;
      adir_r[2] <= adir_z;
      pos_r[0]  <= !in_dir_x[15] && (in_dir_x != 16'sd0);
      pos_r[1]  <= !in_dir_y[15] && (in_dir_y != 16'sd0);
      pos_r[2]  <= !in_dir_z[15] && (in_dir_z != 16'sd0);
      zero_r[0] <= (in_dir_x == 16'sd0);
      zero_r[1] <= (in_dir_y == 16'sd0);
      zero_r[2] <= (in_dir_z == 16'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

endmodule
`default_nettype wire
